@@ src/scl_pkg.sv @@
package scl_pkg;

   localparam int POS_BITS      = 16;
   localparam int FIELD_BITS    = 16;
   localparam int RSPQ_DEPTH    = 4;
   localparam int RSPQ_IDX_BITS = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_BITS = $clog2(RSPQ_DEPTH + 1);

   typedef logic [POS_BITS-1:0]   pos_type;
   typedef logic [FIELD_BITS-1:0] field_type;

   localparam pos_type   POS_MAX   = {POS_BITS{1'b1}};
   localparam field_type FIELD_MAX = {FIELD_BITS{1'b1}};

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_USCORE = 8'h5F;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   localparam logic [1:0] PUSH_NONE = 2'd0;
   localparam logic [1:0] PUSH_ONE  = 2'd1;
   localparam logic [1:0] PUSH_TWO  = 2'd2;

   typedef struct packed {
      logic [7:0] held_char;
      logic       held_valid;
      logic [7:0] prev_char;
      logic       skip_next;
      pos_type    position;
      logic       token_open;
      pos_type    token_begin;
      logic [7:0] token_first_char;
      field_type  line_count;
      field_type  col_count;
      logic       in_line_comment;
      logic       in_block_comment;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      held_char:        8'h00,
      held_valid:       1'b0,
      prev_char:        8'h00,
      skip_next:        1'b0,
      position:         '0,
      token_open:       1'b0,
      token_begin:      '0,
      token_first_char: 8'h00,
      line_count:       field_type'(1),
      col_count:        '0,
      in_line_comment:  1'b0,
      in_block_comment: 1'b0
   };

   typedef struct packed {
      field_type tok_start;
      field_type tok_length;
      field_type tok_line;
      field_type tok_col;
      logic      tok_valid;
      logic      end_of_text;
   } tok_type;

   typedef struct packed {
      logic [1:0] count;
      tok_type    tok_a;
      tok_type    tok_b;
   } push_type;

   typedef struct packed {
      scan_state_type st;
      logic           emit;
      tok_type        tok;
      logic           again;
   } judge_type;

   typedef struct packed {
      scan_state_type st;
      logic           emit;
      tok_type        tok;
   } consume_type;

   function automatic pos_type inc_pos(pos_type v);
      return (v == POS_MAX) ? v : v + pos_type'(1);
   endfunction

   function automatic field_type inc_field(field_type v);
      return (v == FIELD_MAX) ? v : v + field_type'(1);
   endfunction

   function automatic field_type to_field(pos_type p);
      logic [31:0] w;
      w = 32'(p);
      return w[FIELD_BITS-1:0];
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
             ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_USCORE);
   endfunction

   function automatic logic is_rel(logic [7:0] c);
      return (c == CH_EQ) || (c == CH_LT) || (c == CH_GT);
   endfunction

   function automatic logic is_andor(logic [7:0] c);
      return (c == CH_AMP) || (c == CH_BAR);
   endfunction

   function automatic logic is_punct(logic [7:0] c);
      return (c == CH_LPAREN) || (c == CH_LBRACE) || (c == CH_LBRACK) ||
             (c == CH_RPAREN) || (c == CH_RBRACE) || (c == CH_RBRACK) ||
             (c == CH_SEMI) || (c == CH_PLUS) || (c == CH_MINUS) ||
             (c == CH_STAR) || (c == CH_SLASH) || (c == CH_COMMA) ||
             (c == CH_PCT) || (c == CH_CARET);
   endfunction

   function automatic tok_type make_tok(scan_state_type st, pos_type len);
      tok_type t;
      t.tok_start   = to_field(st.token_begin);
      t.tok_length  = to_field(len);
      t.tok_line    = st.line_count;
      t.tok_col     = st.col_count;
      t.tok_valid   = 1'b1;
      t.end_of_text = 1'b0;
      return t;
   endfunction

   function automatic judge_type judge(scan_state_type st, logic [7:0] c, logic [7:0] nx);
      judge_type  r;
      pos_type    excl;
      pos_type    incl;
      logic [7:0] s;
      logic       close;
      logic       close_incl;
      r.st       = st;
      r.emit     = 1'b0;
      r.tok      = '0;
      r.again    = 1'b0;
      s          = st.token_first_char;
      excl       = st.position - st.token_begin;
      incl       = inc_pos(excl);
      close      = 1'b0;
      close_incl = 1'b0;
      if (st.in_line_comment) begin
         if (c == CH_LF) begin
            r.st.in_line_comment = 1'b0;
            r.st.line_count      = inc_field(st.line_count);
            r.st.col_count       = '0;
         end
      end else if (st.in_block_comment) begin
         if ((c == CH_SLASH) && (st.prev_char == CH_STAR)) begin
            r.st.in_block_comment = 1'b0;
         end
      end else if ((c == CH_SLASH) && ((nx == CH_SLASH) || (nx == CH_STAR))) begin
         r.st.in_line_comment  = (nx == CH_SLASH);
         r.st.in_block_comment = (nx == CH_STAR);
         r.st.token_open       = 1'b0;
      end else if (!st.token_open) begin
         if (c == CH_LF) begin
            r.st.line_count = inc_field(st.line_count);
            r.st.col_count  = '0;
         end else if (!is_blank(c)) begin
            r.st.token_open       = 1'b1;
            r.st.token_begin      = st.position;
            r.st.token_first_char = c;
         end
      end else begin
         if (s == CH_DQUOTE) begin
            if ((c == CH_DQUOTE) && (nx == CH_DQUOTE)) begin
               r.st.skip_next = 1'b1;
            end else if (c == CH_DQUOTE) begin
               close_incl = 1'b1;
            end
         end else if (s == CH_SQUOTE) begin
            close_incl = (c == CH_SQUOTE);
         end else if (is_blank(c) || (c == CH_LF)) begin
            r.emit          = 1'b1;
            r.tok           = make_tok(st, excl);
            r.st.token_open = 1'b0;
            if (c == CH_LF) begin
               r.st.line_count = inc_field(st.line_count);
               r.st.col_count  = '0;
            end
         end else if (is_punct(s)) begin
            close = 1'b1;
         end else if (is_digit(s)) begin
            close = !(is_digit(c) || (c == CH_DOT));
         end else if (is_alpha(s)) begin
            close = !(is_alpha(c) || is_digit(c));
         end else if (is_rel(s)) begin
            close = !is_rel(c);
         end else if (is_andor(s)) begin
            close = !is_andor(c);
         end
         if (close_incl) begin
            r.emit          = 1'b1;
            r.tok           = make_tok(st, incl);
            r.st.token_open = 1'b0;
         end else if (close) begin
            r.emit          = 1'b1;
            r.tok           = make_tok(st, excl);
            r.st.token_open = 1'b0;
            r.again         = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic consume_type consume(scan_state_type st, logic [7:0] c, logic [7:0] nx);
      consume_type r;
      judge_type   j1;
      judge_type   j2;
      j1              = judge(st, c, nx);
      j1.st.col_count = inc_field(j1.st.col_count);
      j2              = judge(j1.st, c, nx);
      j2.st.col_count = inc_field(j2.st.col_count);
      r.st            = st;
      r.emit          = 1'b0;
      r.tok           = '0;
      if (st.skip_next) begin
         r.st.skip_next = 1'b0;
      end else begin
         r.emit = j1.emit;
         r.tok  = j1.tok;
         r.st   = j1.again ? j2.st : j1.st;
      end
      r.st.prev_char = c;
      r.st.position  = inc_pos(r.st.position);
      return r;
   endfunction

endpackage

@@ src/scl_req_if.sv @@
interface scl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       is_last;

   modport source (output valid, output ch, output is_last, input ready);
   modport sink (input valid, input ch, input is_last, output ready);
endinterface

@@ src/scl_rsp_if.sv @@
interface scl_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] tok_start;
   logic [15:0] tok_length;
   logic [15:0] tok_line;
   logic [15:0] tok_col;
   logic        tok_valid;
   logic        end_of_text;

   modport source (output valid, output tok_start, output tok_length, output tok_line,
                   output tok_col, output tok_valid, output end_of_text, input ready);
   modport sink (input valid, input tok_start, input tok_length, input tok_line,
                 input tok_col, input tok_valid, input end_of_text, output ready);
endinterface

@@ src/scl_core.sv @@
module scl_core (
   input  logic              clock,
   input  logic              reset,
   scl_req_if.sink           req_bus,
   input  logic              q_room,
   output scl_pkg::push_type push
);
   import scl_pkg::*;

   scan_state_type st_ff;
   scan_state_type st_in;
   logic           flush_ff;
   logic           flush_in;
   logic           take;
   logic [7:0]     nx_char;
   consume_type    cons;
   tok_type        final_tok;

   assign req_bus.ready = !flush_ff && q_room;
   assign take          = req_bus.valid && req_bus.ready;
   assign nx_char       = flush_ff ? CH_NUL : req_bus.ch;
   assign cons          = consume(st_ff, st_ff.held_char, nx_char);

   always_comb begin
      final_tok             = '0;
      final_tok.end_of_text = 1'b1;
      if (cons.st.token_open) begin
         final_tok.tok_start  = to_field(cons.st.token_begin);
         final_tok.tok_length = to_field(cons.st.position - cons.st.token_begin);
         final_tok.tok_valid  = 1'b1;
      end
   end

   always_comb begin
      st_in    = st_ff;
      flush_in = flush_ff;
      push     = '0;
      if (flush_ff) begin
         st_in    = SCAN_RESET;
         flush_in = 1'b0;
         if (cons.emit) begin
            push.count = PUSH_TWO;
            push.tok_a = cons.tok;
            push.tok_b = final_tok;
         end else begin
            push.count = PUSH_ONE;
            push.tok_a = final_tok;
         end
      end else if (take) begin
         if (st_ff.held_valid) begin
            st_in = cons.st;
            if (cons.emit) begin
               push.count = PUSH_ONE;
               push.tok_a = cons.tok;
            end
         end
         st_in.held_char  = req_bus.ch;
         st_in.held_valid = 1'b1;
         flush_in         = req_bus.is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= SCAN_RESET;
         flush_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         flush_ff <= flush_in;
      end
   end

endmodule

@@ src/scl_rspq.sv @@
module scl_rspq (
   input  logic              clock,
   input  logic              reset,
   input  scl_pkg::push_type push,
   output logic              q_room,
   scl_rsp_if.source         rsp_bus
);
   import scl_pkg::*;

   tok_type                  mem_ff [RSPQ_DEPTH];
   logic [RSPQ_IDX_BITS-1:0] head_ff;
   logic [RSPQ_IDX_BITS-1:0] head_in;
   logic [RSPQ_IDX_BITS-1:0] tail_ff;
   logic [RSPQ_IDX_BITS-1:0] tail_in;
   logic [RSPQ_IDX_BITS-1:0] tail_next;
   logic [RSPQ_CNT_BITS-1:0] count_ff;
   logic [RSPQ_CNT_BITS-1:0] count_in;
   logic                     pop;
   tok_type                  head_tok;

   assign pop       = rsp_bus.valid && rsp_bus.ready;
   assign tail_next = tail_ff + RSPQ_IDX_BITS'(1);
   assign tail_in   = tail_ff + RSPQ_IDX_BITS'(push.count);
   assign head_in   = pop ? head_ff + RSPQ_IDX_BITS'(1) : head_ff;
   assign count_in  = count_ff + RSPQ_CNT_BITS'(push.count) - RSPQ_CNT_BITS'(pop);
   assign q_room    = (count_ff <= RSPQ_CNT_BITS'(RSPQ_DEPTH - 3));

   assign head_tok            = mem_ff[head_ff];
   assign rsp_bus.valid       = (count_ff != '0);
   assign rsp_bus.tok_start   = head_tok.tok_start;
   assign rsp_bus.tok_length  = head_tok.tok_length;
   assign rsp_bus.tok_line    = head_tok.tok_line;
   assign rsp_bus.tok_col     = head_tok.tok_col;
   assign rsp_bus.tok_valid   = head_tok.tok_valid;
   assign rsp_bus.end_of_text = head_tok.end_of_text;

   always_ff @(posedge clock) begin
      if (push.count != PUSH_NONE) begin
         mem_ff[tail_ff] <= push.tok_a;
      end
      if (push.count == PUSH_TWO) begin
         mem_ff[tail_next] <= push.tok_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ src/script_lexer_token_boundaries.sv @@
// Throughput: one request per cycle while the result queue holds at most one result; the
//    request marked last is followed by a flush state in which no request is taken,
//    and ready then stays low while the queue holds more than one result.
// Lookahead: a character is judged when the next request is taken (one character of
//    lookahead), the last one in the flush; its token is then registered in the result queue.
// Reset (synchronous, active high) empties the result queue and returns the scanner
//    to its start state, line counter at one; the same state follows each flush.
module script_lexer_token_boundaries (
   input logic       clock,
   input logic       reset,
   scl_req_if.sink   req_bus,
   scl_rsp_if.source rsp_bus
);
   import scl_pkg::*;

   push_type push;
   logic     q_room;

   scl_core u_core (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_room  (q_room),
      .push    (push)
   );

   scl_rspq u_rspq (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .q_room  (q_room),
      .rsp_bus (rsp_bus)
   );

endmodule

@@ src/scl_checker.sv @@
module scl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_is_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_tok_start,
   input logic [15:0] rsp_tok_length,
   input logic [15:0] rsp_tok_line,
   input logic [15:0] rsp_tok_col,
   input logic        rsp_tok_valid,
   input logic        rsp_end_of_text
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tok_start) &&
      $stable(rsp_tok_length) && $stable(rsp_tok_line) && $stable(rsp_tok_col) &&
      $stable(rsp_tok_valid) && $stable(rsp_end_of_text))
      else $error("response changed while stalled");

   a_flush_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_is_last |=> !req_ready)
      else $error("request taken during end-of-text flush");

   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tok_valid |-> rsp_end_of_text && rsp_tok_start == 16'd0 &&
      rsp_tok_length == 16'd0 && rsp_tok_line == 16'd0 && rsp_tok_col == 16'd0)
      else $error("empty marker with nonzero fields");

   a_flush_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_text |-> rsp_tok_line == 16'd0 && rsp_tok_col == 16'd0)
      else $error("end-of-text result with line or column set");

   a_mid_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_text |-> rsp_tok_valid)
      else $error("ordinary result without a token");

endmodule

bind script_lexer_token_boundaries scl_checker u_scl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_is_last     (req_bus.is_last),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_tok_start   (rsp_bus.tok_start),
   .rsp_tok_length  (rsp_bus.tok_length),
   .rsp_tok_line    (rsp_bus.tok_line),
   .rsp_tok_col     (rsp_bus.tok_col),
   .rsp_tok_valid   (rsp_bus.tok_valid),
   .rsp_end_of_text (rsp_bus.end_of_text)
);
